// ----- src/bse_pkg.sv -----
`default_nettype none

package bse_pkg;

   // Fixed-point formats and widths
   localparam int unsigned WORD_W = 32;
   localparam int unsigned PROD_W = 64;
   localparam int unsigned SUM_W  = 44;
   localparam int unsigned DIFF_W = 13;
   localparam int unsigned ITER_W = 12;
   localparam int unsigned CSR_INDEX_W = 8;

   // Mapping constants in Q8.24
   localparam logic signed [WORD_W-1:0] STEP_Q    = 32'sd83886;
   localparam logic signed [WORD_W-1:0] BIAS_RE_Q = 32'sd3355443;
   localparam logic signed [WORD_W-1:0] BIAS_IM_Q = 32'sd5033165;

   // Escape radius squared, 30 in Q16.48
   localparam logic [PROD_W-1:0] ESCAPE_Q48 = 64'h001E_0000_0000_0000;

   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ZOOM_SCALE     = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_REAL    = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_OFFSET_IMAG    = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_ITERATIONS = 8'd3;

   // Register reset values
   localparam logic [30:0]              ZOOM_RESET   = 31'd335544;
   localparam logic signed [WORD_W-1:0] OFF_RE_RESET = -32'sd29360128;
   localparam logic signed [WORD_W-1:0] OFF_IM_RESET = -32'sd503317;
   localparam logic [ITER_W-1:0]        ITER_RESET   = 12'd30;

   typedef struct packed {
      logic [30:0]              zoom_scale;
      logic signed [WORD_W-1:0] offset_real;
      logic signed [WORD_W-1:0] offset_imag;
      logic [ITER_W-1:0]        max_iterations;
   } cfg_type;

   typedef struct packed {
      logic              escaped;
      logic [ITER_W-1:0] iteration_index;
   } res_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MXA,
      ST_MXB,
      ST_MXC,
      ST_MXD,
      ST_MYB,
      ST_MYC,
      ST_MYD,
      ST_UPD,
      ST_SQR,
      ST_SQI,
      ST_CRS,
      ST_DONE
   } state_type;

   // Clamp a wide sum to the signed 32-bit range
   function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] hi;
      logic signed [SUM_W-1:0] lo;
      hi = SUM_W'(WORD_MAX);
      lo = SUM_W'(WORD_MIN);
      if (v > hi) begin
         return WORD_MAX;
      end else if (v < lo) begin
         return WORD_MIN;
      end else begin
         return v[WORD_W-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ----- src/bse_ifs.sv -----
`default_nettype none

// Pixel request channel
interface bse_req_if;
   logic       valid;
   logic       ready;
   logic [9:0] pixel_x;
   logic [8:0] pixel_y;
   logic       mode;

   modport source (output valid, output pixel_x, output pixel_y, output mode, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input mode, output ready);
endinterface

// Escape result channel
interface bse_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          escaped;
   logic [bse_pkg::ITER_W-1:0]    iteration_index;

   modport source (output valid, output escaped, output iteration_index, input ready);
   modport sink   (input valid, input escaped, input iteration_index, output ready);
endinterface

// Register write channel
interface bse_csr_if;
   logic                              valid;
   logic                              ready;
   logic [bse_pkg::CSR_INDEX_W-1:0]   index;
   logic [bse_pkg::WORD_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- src/bse_csr.sv -----
`default_nettype none

module bse_csr (
   input  wire             clock,
   input  wire             reset,
   bse_csr_if.sink         csr_port,
   output bse_pkg::cfg_type cfg
);

   bse_pkg::cfg_type cfg_ff;
   bse_pkg::cfg_type cfg_in;

   assign csr_port.ready = 1'b1;
   assign cfg = cfg_ff;

   // Decode a register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_port.valid) begin
         unique case (csr_port.index)
            bse_pkg::CSR_ZOOM_SCALE:     cfg_in.zoom_scale     = csr_port.data[30:0];
            bse_pkg::CSR_OFFSET_REAL:    cfg_in.offset_real    = $signed(csr_port.data);
            bse_pkg::CSR_OFFSET_IMAG:    cfg_in.offset_imag    = $signed(csr_port.data);
            bse_pkg::CSR_MAX_ITERATIONS: cfg_in.max_iterations =
               csr_port.data[bse_pkg::ITER_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.zoom_scale     <= bse_pkg::ZOOM_RESET;
         cfg_ff.offset_real    <= bse_pkg::OFF_RE_RESET;
         cfg_ff.offset_imag    <= bse_pkg::OFF_IM_RESET;
         cfg_ff.max_iterations <= bse_pkg::ITER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

// ----- src/bse_mul.sv -----
`default_nettype none

module bse_mul (
   input  wire                                   clock,
   input  wire logic signed [bse_pkg::WORD_W-1:0] op_a,
   input  wire logic signed [bse_pkg::WORD_W-1:0] op_b,
   output logic signed [bse_pkg::PROD_W-1:0]      prod
);

   logic signed [bse_pkg::PROD_W-1:0] prod_ff;
   logic signed [bse_pkg::PROD_W-1:0] prod_in;

   // Full signed 32x32 product, registered
   assign prod_in = bse_pkg::PROD_W'(op_a) * bse_pkg::PROD_W'(op_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

// ----- src/bse_engine.sv -----
`default_nettype none

module bse_engine #(
   parameter int MAIN_WIDTH     = 1024,
   parameter int MAIN_HEIGHT    = 512,
   parameter int PREVIEW_WIDTH  = 256,
   parameter int PREVIEW_HEIGHT = 256
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire bse_pkg::cfg_type                 cfg,
   input  wire                                   req_take,
   input  wire logic [9:0]                       pixel_x,
   input  wire logic [8:0]                       pixel_y,
   input  wire                                   mode,
   input  wire                                   out_free,
   output logic                                  idle,
   output logic                                  res_valid,
   output bse_pkg::res_type                      res,
   output logic signed [bse_pkg::WORD_W-1:0]     op_a,
   output logic signed [bse_pkg::WORD_W-1:0]     op_b,
   input  wire logic signed [bse_pkg::PROD_W-1:0] prod
);

   localparam int unsigned DW = bse_pkg::DIFF_W;
   localparam int unsigned WW = bse_pkg::WORD_W;
   localparam int unsigned PW = bse_pkg::PROD_W;
   localparam int unsigned SW = bse_pkg::SUM_W;
   localparam int unsigned IW = bse_pkg::ITER_W;

   localparam logic signed [DW-1:0] HALF_MW = DW'(MAIN_WIDTH / 2);
   localparam logic signed [DW-1:0] HALF_MH = DW'(MAIN_HEIGHT / 2);
   localparam logic signed [DW-1:0] HALF_PW = DW'(PREVIEW_WIDTH / 2);
   localparam logic signed [DW-1:0] HALF_PH = DW'(PREVIEW_HEIGHT / 2);

   bse_pkg::state_type state_ff, state_in;

   logic signed [DW-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [WW-1:0] t_ff, t_in;
   logic signed [WW-1:0] cr_ff, cr_in, ci_ff, ci_in;
   logic signed [WW-1:0] re_ff, re_in, im_ff, im_in;
   logic signed [PW-1:0] rr_ff, rr_in, ii_ff, ii_in;
   logic [IW-1:0]        k_ff, k_in;
   logic                 esc_ff, esc_in;
   logic [IW-1:0]        idx_ff, idx_in;

   logic signed [WW-1:0] zoom_op;
   logic signed [SW-1:0] map_sum_re, map_sum_im;
   logic signed [PW-1:0] sq_diff;
   logic [PW-1:0]        cross_abs;
   logic signed [SW-1:0] new_re_sum, new_im_sum;
   logic [PW-1:0]        mag;
   logic                 escape_hit;
   logic                 last_iter;

   assign zoom_op = $signed({1'b0, cfg.zoom_scale});

   // Finish the mapping: floor shift of t*zoom plus pan
   assign map_sum_re = SW'(prod >>> 24) + SW'(cfg.offset_real);
   assign map_sum_im = SW'(prod >>> 24) + SW'(cfg.offset_imag);

   // Next orbit point from the squares and the cross product
   assign sq_diff    = rr_ff - ii_ff;
   assign cross_abs  = prod[PW-1] ? PW'(-prod) : PW'(prod);
   assign new_re_sum = SW'(sq_diff >>> 24) + SW'(cr_ff);
   assign new_im_sum = $signed(SW'(cross_abs >> 23)) + SW'(ci_ff);

   // Escape test on |z|^2 in Q16.48
   assign mag        = PW'(rr_ff) + PW'(prod);
   assign escape_hit = (mag >= bse_pkg::ESCAPE_Q48);
   assign last_iter  = (k_ff == cfg.max_iterations - IW'(1));

   assign idle      = (state_ff == bse_pkg::ST_IDLE);
   assign res_valid = (state_ff == bse_pkg::ST_DONE);
   assign res.escaped         = esc_ff;
   assign res.iteration_index = idx_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bse_pkg::ST_IDLE: begin
            if (req_take) begin
               state_in = (cfg.max_iterations == '0) ? bse_pkg::ST_DONE : bse_pkg::ST_MXA;
            end
         end
         bse_pkg::ST_MXA: state_in = bse_pkg::ST_MXB;
         bse_pkg::ST_MXB: state_in = bse_pkg::ST_MXC;
         bse_pkg::ST_MXC: state_in = bse_pkg::ST_MXD;
         bse_pkg::ST_MXD: state_in = bse_pkg::ST_MYB;
         bse_pkg::ST_MYB: state_in = bse_pkg::ST_MYC;
         bse_pkg::ST_MYC: state_in = bse_pkg::ST_MYD;
         bse_pkg::ST_MYD: state_in = bse_pkg::ST_UPD;
         bse_pkg::ST_UPD: state_in = bse_pkg::ST_SQR;
         bse_pkg::ST_SQR: state_in = bse_pkg::ST_SQI;
         bse_pkg::ST_SQI: state_in = bse_pkg::ST_CRS;
         bse_pkg::ST_CRS: begin
            state_in = (escape_hit || last_iter) ? bse_pkg::ST_DONE : bse_pkg::ST_UPD;
         end
         bse_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = bse_pkg::ST_IDLE;
            end
         end
         default: state_in = bse_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and register updates
   always_comb begin
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      t_in   = t_ff;
      cr_in  = cr_ff;
      ci_in  = ci_ff;
      re_in  = re_ff;
      im_in  = im_ff;
      rr_in  = rr_ff;
      ii_in  = ii_ff;
      k_in   = k_ff;
      esc_in = esc_ff;
      idx_in = idx_ff;
      op_a   = '0;
      op_b   = '0;
      unique case (state_ff)
         bse_pkg::ST_IDLE: begin
            // Center the pixel on its window
            dx_in  = $signed(DW'(pixel_x)) - (mode ? HALF_PW : HALF_MW);
            dy_in  = $signed(DW'(pixel_y)) - (mode ? HALF_PH : HALF_MH);
            k_in   = '0;
            esc_in = 1'b0;
            idx_in = '0;
         end
         bse_pkg::ST_MXA: begin
            op_a = WW'(dx_ff);
            op_b = bse_pkg::STEP_Q;
         end
         bse_pkg::ST_MXB: t_in = WW'(prod - PW'(bse_pkg::BIAS_RE_Q));
         bse_pkg::ST_MXC: begin
            op_a = t_ff;
            op_b = zoom_op;
         end
         bse_pkg::ST_MXD: begin
            cr_in = bse_pkg::sat32(map_sum_re);
            op_a  = WW'(dy_ff);
            op_b  = bse_pkg::STEP_Q;
         end
         bse_pkg::ST_MYB: t_in = WW'(prod - PW'(bse_pkg::BIAS_IM_Q));
         bse_pkg::ST_MYC: begin
            op_a = t_ff;
            op_b = zoom_op;
         end
         bse_pkg::ST_MYD: ci_in = bse_pkg::sat32(map_sum_im);
         bse_pkg::ST_UPD: begin
            // First step from zero lands on c itself
            if (k_ff == '0) begin
               re_in = cr_ff;
               im_in = ci_ff;
            end else begin
               re_in = bse_pkg::sat32(new_re_sum);
               im_in = bse_pkg::sat32(new_im_sum);
            end
         end
         bse_pkg::ST_SQR: begin
            op_a = re_ff;
            op_b = re_ff;
         end
         bse_pkg::ST_SQI: begin
            rr_in = prod;
            op_a  = im_ff;
            op_b  = im_ff;
         end
         bse_pkg::ST_CRS: begin
            ii_in = prod;
            op_a  = re_ff;
            op_b  = im_ff;
            if (escape_hit) begin
               esc_in = 1'b1;
               idx_in = k_ff;
            end else if (last_iter) begin
               esc_in = 1'b0;
               idx_in = cfg.max_iterations;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         bse_pkg::ST_DONE: begin
            op_a = '0;
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bse_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      t_ff   <= t_in;
      cr_ff  <= cr_in;
      ci_ff  <= ci_in;
      re_ff  <= re_in;
      im_ff  <= im_in;
      rr_ff  <= rr_in;
      ii_ff  <= ii_in;
      k_ff   <= k_in;
      esc_ff <= esc_in;
      idx_ff <= idx_in;
   end

endmodule

`default_nettype wire

// ----- src/burning_ship_escape_time_core.sv -----
`default_nettype none
// A request is mapped and then iterated for n orbit steps, n = iterations run
// (1 <= n <= max_iterations); with max_iterations zero it goes straight to the result.
// One request at a time: a new one is taken only once the sequencer is idle again, as
// the single shared 32x32 multiplier serves three products per orbit step plus four for mapping.
// Reset: synchronous, active high; sequencer idle, output empty, registers at defaults.
module burning_ship_escape_time_core #(
   parameter int MAIN_WIDTH     = 1024,
   parameter int MAIN_HEIGHT    = 512,
   parameter int PREVIEW_WIDTH  = 256,
   parameter int PREVIEW_HEIGHT = 256
) (
   input  wire         clock,
   input  wire         reset,
   bse_req_if.sink     req_port,
   bse_rsp_if.source   rsp_port,
   bse_csr_if.sink     csr_port
);

   bse_pkg::cfg_type cfg;
   bse_pkg::res_type res;

   logic                                  idle;
   logic                                  res_valid;
   logic                                  req_take;
   logic                                  out_free;
   logic signed [bse_pkg::WORD_W-1:0]     op_a;
   logic signed [bse_pkg::WORD_W-1:0]     op_b;
   logic signed [bse_pkg::PROD_W-1:0]     prod;

   logic             rsp_valid_ff, rsp_valid_in;
   bse_pkg::res_type rsp_res_ff, rsp_res_in;

   assign req_port.ready = idle;
   assign req_take       = req_port.valid && idle;
   assign out_free       = !rsp_valid_ff || rsp_port.ready;

   bse_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .csr_port (csr_port),
      .cfg      (cfg)
   );

   bse_mul u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   bse_engine #(
      .MAIN_WIDTH     (MAIN_WIDTH),
      .MAIN_HEIGHT    (MAIN_HEIGHT),
      .PREVIEW_WIDTH  (PREVIEW_WIDTH),
      .PREVIEW_HEIGHT (PREVIEW_HEIGHT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_take  (req_take),
      .pixel_x   (req_port.pixel_x),
      .pixel_y   (req_port.pixel_y),
      .mode      (req_port.mode),
      .out_free  (out_free),
      .idle      (idle),
      .res_valid (res_valid),
      .res       (res),
      .op_a      (op_a),
      .op_b      (op_b),
      .prod      (prod)
   );

   // Hold the finished result until the sink takes it
   always_comb begin
      rsp_res_in   = rsp_res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      if (res_valid && out_free) begin
         rsp_res_in   = res;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.escaped         = rsp_res_ff.escaped;
   assign rsp_port.iteration_index = rsp_res_ff.iteration_index;

endmodule

`default_nettype wire

// ----- test/burning_ship_escape_time_checker.sv -----
// Watches the pixel, result and register channels of the escape-time core,
// forecasts every result from its own copy of the registers and compares.
module burning_ship_escape_time_checker (
   input  wire  clock,
   input  wire  reset,
   bse_req_if   req_mon,
   bse_rsp_if   rsp_mon,
   bse_csr_if   csr_mon,
   output int   fail_count,
   output int   results_seen,
   output int   escaped_seen,
   output int   orbits_left
);
   import bse_pkg::*;

   // Window sizes match the core's default parameters
   localparam longint MAIN_W    = 1024;
   localparam longint MAIN_H    = 512;
   localparam longint PREVIEW_W = 256;
   localparam longint PREVIEW_H = 256;

   // Q8.24 mapping constants and the Q16.48 escape radius
   localparam longint      PIXEL_STEP  = 64'sd83886;
   localparam longint      BIAS_RE     = 64'sd3355443;
   localparam longint      BIAS_IM     = 64'sd5033165;
   localparam logic [63:0] ESCAPE_BND  = 64'd30 << 48;
   localparam longint      WORD_HI     = 64'sd2147483647;
   localparam longint      WORD_LO     = -64'sd2147483648;

   typedef struct {
      logic [9:0] px;
      logic [8:0] py;
      logic       mode;
      res_type    want;
   } orbit_case;

   orbit_case pending_orbits[$];

   // Shadow of the register file
   longint zoom_q;
   longint off_re_q;
   longint off_im_q;
   int     iter_limit;

   function automatic longint clamp_word(input longint v);
      if (v > WORD_HI) return WORD_HI;
      if (v < WORD_LO) return WORD_LO;
      return v;
   endfunction

   // Pixel to Q8.24 coordinate: center, step, bias, zoom, then pan
   function automatic longint map_axis(input longint pix, input longint dim,
                                       input longint bias, input longint offs);
      longint span;
      longint scaled;
      span   = (pix - dim / 2) * PIXEL_STEP - bias;
      scaled = span * zoom_q;
      return clamp_word((scaled >>> 24) + offs);
   endfunction

   // Run the Burning Ship orbit from zero until it leaves radius^2 30 or reaches the limit
   function automatic res_type trace_orbit(input logic [9:0] px, input logic [8:0] py,
                                           input logic m);
      longint      cr;
      longint      ci;
      longint      re;
      longint      im;
      longint      rr;
      longint      ii;
      longint      ri;
      longint      nre;
      longint      nim;
      logic [63:0] mag;
      res_type     r;
      bit          hit;
      int          k;
      cr = map_axis(longint'(px), m ? PREVIEW_W : MAIN_W, BIAS_RE, off_re_q);
      ci = map_axis(longint'(py), m ? PREVIEW_H : MAIN_H, BIAS_IM, off_im_q);
      re = 0;
      im = 0;
      hit = 1'b0;
      r.escaped = 1'b0;
      r.iteration_index = ITER_W'(iter_limit);
      for (k = 0; k < iter_limit && !hit; k++) begin
         rr = re * re;
         ii = im * im;
         ri = re * im;
         if (ri < 0) ri = -ri;
         nre = clamp_word(((rr - ii) >>> 24) + cr);
         nim = clamp_word((ri >>> 23) + ci);
         re = nre;
         im = nim;
         mag = re * re + im * im;
         if (mag >= ESCAPE_BND) begin
            hit = 1'b1;
            r.escaped = 1'b1;
            r.iteration_index = ITER_W'(k);
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      orbit_case head;
      orbit_case fresh;
      int        errs;
      errs = 0;
      if (reset) begin
         zoom_q   <= longint'(ZOOM_RESET);
         off_re_q <= longint'(OFF_RE_RESET);
         off_im_q <= longint'(OFF_IM_RESET);
         iter_limit <= int'(ITER_RESET);
         pending_orbits.delete();
         fail_count   <= 0;
         results_seen <= 0;
         escaped_seen <= 0;
         orbits_left  <= 0;
      end else begin
         // Compare a returned result against the oldest forecast
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_orbits.size() == 0) begin
               $error("unexpected result: escaped %0d index %0d",
                      rsp_mon.escaped, rsp_mon.iteration_index);
               errs++;
            end else begin
               head = pending_orbits.pop_front();
               if (rsp_mon.escaped !== head.want.escaped) begin
                  $error("escaped: expected %0d, actual %0d (x %0d y %0d mode %0d)",
                         head.want.escaped, rsp_mon.escaped, head.px, head.py, head.mode);
                  errs++;
               end
               if (rsp_mon.iteration_index !== head.want.iteration_index) begin
                  $error("iteration_index: expected %0d, actual %0d (x %0d y %0d mode %0d)",
                         head.want.iteration_index, rsp_mon.iteration_index,
                         head.px, head.py, head.mode);
                  errs++;
               end
            end
            results_seen <= results_seen + 1;
            if (rsp_mon.escaped === 1'b1) escaped_seen <= escaped_seen + 1;
         end

         // Forecast each accepted request with the registers in force now
         if (req_mon.valid && req_mon.ready) begin
            fresh.px   = req_mon.pixel_x;
            fresh.py   = req_mon.pixel_y;
            fresh.mode = req_mon.mode;
            fresh.want = trace_orbit(req_mon.pixel_x, req_mon.pixel_y, req_mon.mode);
            pending_orbits.push_back(fresh);
         end

         // Track register writes; unknown indexes are ignored
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_ZOOM_SCALE:     zoom_q   <= longint'(csr_mon.data[30:0]);
               CSR_OFFSET_REAL:    off_re_q <= longint'($signed(csr_mon.data));
               CSR_OFFSET_IMAG:    off_im_q <= longint'($signed(csr_mon.data));
               CSR_MAX_ITERATIONS: iter_limit <= int'(csr_mon.data[ITER_W-1:0]);
               default: ;
            endcase
         end

         fail_count  <= fail_count + errs;
         orbits_left <= pending_orbits.size();
      end
   end

endmodule

// ----- test/burning_ship_escape_time_core_tb.sv -----
module burning_ship_escape_time_core_tb;
   import bse_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 8'hC8;
   localparam int RANDOM_REQUESTS = 1930;

   logic clock;
   logic reset;

   bse_req_if req_if ();
   bse_rsp_if rsp_if ();
   bse_csr_if csr_if ();

   int     fail_count;
   int     results_seen;
   int     escaped_seen;
   int     orbits_left;
   int     requests_sent = 0;
   int     settings_used = 1;
   int     cur_limit = int'(ITER_RESET);
   longint cycle_budget = 0;
   longint cycle_count = 0;
   bit     req_burst = 1'b0;
   bit     rsp_burst = 1'b0;

   burning_ship_escape_time_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if),
      .rsp_port (rsp_if),
      .csr_port (csr_if)
   );

   burning_ship_escape_time_checker scoreboard (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_if),
      .rsp_mon      (rsp_if),
      .csr_mon      (csr_if),
      .fail_count   (fail_count),
      .results_seen (results_seen),
      .escaped_seen (escaped_seen),
      .orbits_left  (orbits_left)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Abort when the run outgrows several times its worst-case length
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 4 * cycle_budget + 50000) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Stall the result side before each result, with stretches of no stall
   initial begin
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 63) == 0) rsp_burst = !rsp_burst;
         stall = rsp_burst ? 0 : $urandom_range(0, 10);
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_if.valid && rsp_if.ready)) @(posedge clock);
      end
   end

   // Send one pixel request after a random gap and hold it until taken
   task automatic issue_pixel(input logic [9:0] px, input logic [8:0] py, input logic m);
      int gap;
      if ($urandom_range(0, 63) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.pixel_x <= px;
      req_if.pixel_y <= py;
      req_if.mode    <= m;
      cycle_budget += 9 + 4 * cur_limit + 24;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      requests_sent++;
   endtask

   // Drop the request line and wait for every result to come back
   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (results_seen != requests_sent) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
   endtask

   // Load a full window setting while the core is idle; unused bits are random
   task automatic set_window(input logic [30:0] zoom, input logic [31:0] ore,
                             input logic [31:0] oim, input logic [11:0] lim);
      drain_results();
      write_reg(CSR_ZOOM_SCALE, {1'($urandom_range(0, 1)), zoom});
      write_reg(CSR_OFFSET_REAL, ore);
      write_reg(CSR_OFFSET_IMAG, oim);
      write_reg(CSR_MAX_ITERATIONS, {20'($urandom()), lim});
      csr_if.valid <= 1'b0;
      cur_limit = int'(lim);
      settings_used++;
   endtask

   // Pick a window mostly around the ship, sometimes anywhere or at the rails
   task automatic pick_random_window(output int count);
      logic [30:0] zoom;
      logic [31:0] ore;
      logic [31:0] oim;
      logic [11:0] lim;
      int          r;
      r = $urandom_range(0, 9);
      if (r < 6) zoom = 31'($urandom_range(1000, 1 << 23));
      else if (r < 8) zoom = 31'($urandom());
      else if (r == 8) zoom = '0;
      else zoom = 31'h7FFF_FFFF;
      r = $urandom_range(0, 9);
      if (r < 7) begin
         ore = 32'($urandom_range(0, 58720256)) - 32'd41943040;
         oim = 32'($urandom_range(0, 41943040)) - 32'd25165824;
      end else if (r < 9) begin
         ore = $urandom();
         oim = $urandom();
      end else begin
         ore = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         oim = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      end
      r = $urandom_range(0, 19);
      if (r < 14) lim = 12'($urandom_range(2, 64));
      else if (r == 14) lim = '0;
      else if (r == 15) lim = 12'd1;
      else if (r < 18) lim = 12'($urandom_range(65, 300));
      else if (r == 18) lim = 12'($urandom_range(301, 1000));
      else lim = 12'd4095;
      if (lim <= 64) count = $urandom_range(20, 90);
      else if (lim <= 300) count = $urandom_range(8, 16);
      else if (lim <= 1000) count = $urandom_range(3, 6);
      else count = 2;
      set_window(zoom, ore, oim, lim);
   endtask

   initial begin
      int          count;
      int          sent_random;
      int          i;
      logic [9:0]  px;
      logic [8:0]  py;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.pixel_x <= '0;
      req_if.pixel_y <= '0;
      req_if.mode    <= 1'b0;
      csr_if.valid   <= 1'b0;
      csr_if.index   <= '0;
      csr_if.data    <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset window: corners, center and out-of-window preview pixels
      issue_pixel(10'd0, 9'd0, 1'b0);
      issue_pixel(10'd1023, 9'd511, 1'b0);
      issue_pixel(10'd512, 9'd256, 1'b0);
      issue_pixel(10'd0, 9'd511, 1'b1);
      issue_pixel(10'd128, 9'd128, 1'b1);
      issue_pixel(10'd1023, 9'd0, 1'b1);
      issue_pixel(10'd255, 9'd255, 1'b1);
      issue_pixel(10'd700, 9'd300, 1'b0);

      // Write to an index that maps to no register, then saturate everything
      drain_results();
      write_reg(CSR_UNUSED, $urandom());
      set_window(31'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 12'd30);
      issue_pixel(10'd0, 9'd0, 1'b0);
      issue_pixel(10'd1023, 9'd511, 1'b1);

      // Zero zoom and pan keep c at the origin for the full limit
      set_window('0, '0, '0, 12'd4095);
      issue_pixel(10'd512, 9'd256, 1'b0);

      // Zero limit returns at once
      set_window(ZOOM_RESET, OFF_RE_RESET, OFF_IM_RESET, 12'd0);
      issue_pixel(10'd0, 9'd0, 1'b0);
      issue_pixel(10'd1023, 9'd511, 1'b1);

      // Single iteration
      set_window(ZOOM_RESET, OFF_RE_RESET, OFF_IM_RESET, 12'd1);
      issue_pixel(10'd0, 9'd0, 1'b0);
      issue_pixel(10'd600, 9'd200, 1'b0);

      // Opposite rails on the pan
      set_window(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 12'd2);
      issue_pixel(10'd1023, 9'd0, 1'b0);
      issue_pixel(10'd0, 9'd511, 1'b1);

      // Random windows, each with a batch of random pixels
      sent_random = 0;
      while (sent_random < RANDOM_REQUESTS) begin
         pick_random_window(count);
         for (i = 0; i < count && sent_random < RANDOM_REQUESTS; i++) begin
            px = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 10'd1023 : 10'd0)
                                             : 10'($urandom_range(0, 1023));
            py = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 9'd511 : 9'd0)
                                             : 9'($urandom_range(0, 511));
            issue_pixel(px, py, 1'($urandom_range(0, 1)));
            sent_random++;
         end
      end

      // Let the last results land, then watch for strays
      drain_results();
      cycle_budget += 200;
      repeat (64) @(posedge clock);

      $display("Checked %0d pixel results across %0d register settings: %0d escaped, %0d bounded.",
               results_seen, settings_used, escaped_seen, results_seen - escaped_seen);
      $display("Limits ran from zero to 4095; zoom and pan reached both saturation rails.");
      if (fail_count == 0 && orbits_left == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
